// ===== rtl/stbh_pkg.sv =====
`default_nettype none
package stbh_pkg;
  localparam int ROWS = 8;
  localparam int ROW_BITS = 3;
  localparam int SEED_MAX = 8;
  localparam logic OP_HASH = 1'b0;
  localparam logic OP_RESEED = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/seeded_tabulated_byte_hash_unit.sv =====
`default_nettype none
// Channel  Dir  tdata fields (low bit up)              tuser
// s_axis   in   data_byte[7:0], seed_value[71:8]        opcode
// m_axis   out  hash_byte[7:0]                          reseeded
// A hash steps from the accept through 8 table reads, each a read state and then
// an accumulate state, and then loads the output register.
// A reseed walks the table with one single-port read or write per cycle:
// a fill that writes every entry, then (SEED_BYTES + 2) remix passes, with
// one seed byte mixed into one entry between each pair of the first SEED_BYTES + 1.
// Reset clears the table, writing each of its 8 * 2^INDEX_BITS entries in turn.
// The next word is taken while a result waits in the output register;
// a new result stalls until that register is free.
module seeded_tabulated_byte_hash_unit #(
  parameter int INDEX_BITS = 4,
  parameter int SEED_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // data_byte, seed_value
  input  wire logic        s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // hash_byte
  output logic             m_axis_tuser   // reseeded
);
  import stbh_pkg::*;

  localparam int COLS = 1 << INDEX_BITS;
  localparam int AW = INDEX_BITS + ROW_BITS;
  localparam int DEPTH = ROWS * COLS;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_H_RD, S_H_ACC, S_H_END,
    S_F_WR, S_R_PRE, S_R_RD, S_R_WAIT, S_R_HASH, S_R_WR, S_R_OFS,
    S_K_RD, S_K_WAIT, S_K_H1, S_K_H2, S_K_WR, S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    R_HASH, R_PRE, R_CHAIN, R_OFS, R_K1, R_K2, R_FIN
  } ret_t;

  state_t state;
  ret_t ret;
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] addr;
  logic we;
  logic [7:0] wdata;

  logic [7:0] offset, acc, hbyte, chain, cur, n;
  logic [2:0] step;
  logic [AW:0] cnt;
  logic [INDEX_BITS-1:0] col, pos_c;
  logic [ROW_BITS-1:0] row, pos_r;
  logic [3:0] kidx;
  logic [3:0] pass;
  logic [63:0] seed;
  logic [15:0] word;
  logic out_load;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  logic [15:0] hw;
  assign hw = {hbyte, hbyte} >> step;

  always_comb begin
    addr = '0;
    we = 1'b0;
    wdata = '0;
    word = '0;
    case (state)
      S_CLR: begin
        addr = cnt[AW-1:0];
        we = 1'b1;
      end
      S_H_RD, S_H_ACC: addr = {step, hw[INDEX_BITS-1:0]};
      S_F_WR: begin
        addr = {row, col};
        we = 1'b1;
        word = {8'd0, n + 8'd1 + 8'(col)} * {8'd0, n + 8'd1 + 8'(row)};
        wdata = word[7:0];
      end
      S_R_RD, S_R_WAIT: addr = {row, col};
      S_R_WR: begin
        addr = {row, col};
        we = 1'b1;
        wdata = acc;
      end
      S_K_RD, S_K_WAIT: addr = {pos_r, pos_c};
      S_K_WR: begin
        addr = {pos_r, pos_c};
        we = 1'b1;
        wdata = acc;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  // result may load once the output register is empty or being drained
  assign out_load = (state == S_H_END) && (ret == R_HASH || ret == R_FIN)
                    && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      offset <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          seed <= s_axis_tdata[71:8];
          if (s_axis_tuser == OP_RESEED) begin
            row <= '0;
            col <= '0;
            n <= '0;
            state <= S_F_WR;
          end else begin
            hbyte <= s_axis_tdata[7:0];
            acc <= offset;
            step <= '0;
            ret <= R_HASH;
            state <= S_H_RD;
          end
        end
        S_H_RD: state <= S_H_ACC;
        S_H_ACC: begin
          // rdata valid for current step
          acc <= acc + rdata;
          if (step == 3'd7) state <= S_H_END;
          else begin
            step <= step + 1'b1;
            state <= S_H_RD;
          end
        end
        S_H_END: begin
          case (ret)
            R_HASH: begin
              if (out_load) begin
                m_axis_tdata <= acc;
                m_axis_tuser <= 1'b0;
                state <= S_IDLE;
              end
            end
            R_PRE: begin
              chain <= acc;
              row <= '0;
              col <= '0;
              state <= S_R_RD;
            end
            R_CHAIN: state <= S_R_WR;
            R_OFS: begin
              offset <= acc;
              state <= S_R_OFS;
            end
            R_K1: begin
              offset <= acc;
              hbyte <= cur + acc;
              acc <= acc;
              ret <= R_K2;
              step <= '0;
              state <= S_K_H2;
            end
            R_K2: state <= S_K_WR;
            default: begin
              if (out_load) begin
                offset <= acc;
                m_axis_tdata <= '0;
                m_axis_tuser <= 1'b1;
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_F_WR: begin
          n <= n + 1'b1;
          if (row == ROW_BITS'(ROWS - 1)) begin
            row <= '0;
            col <= col + 1'b1;
            if (col == INDEX_BITS'(COLS - 1)) begin
              offset <= n + 8'd2;
              pass <= '0;
              pos_c <= '0;
              pos_r <= '0;
              kidx <= '0;
              state <= S_R_PRE;
            end
          end else row <= row + 1'b1;
        end
        S_R_PRE: begin
          hbyte <= offset;
          acc <= offset;
          step <= '0;
          ret <= R_PRE;
          state <= S_H_RD;
        end
        S_R_RD: state <= S_R_WAIT;
        S_R_WAIT: state <= S_R_HASH;
        S_R_HASH: begin
          hbyte <= chain + 8'(row) + 8'(col) + rdata;
          acc <= offset;
          step <= '0;
          ret <= R_CHAIN;
          state <= S_H_RD;
        end
        S_R_WR: begin
          chain <= acc;
          if (row == ROW_BITS'(ROWS - 1)) begin
            row <= '0;
            col <= col + 1'b1;
            if (col == INDEX_BITS'(COLS - 1)) begin
              hbyte <= offset;
              acc <= offset;
              step <= '0;
              ret <= R_OFS;
              state <= S_H_RD;
            end else state <= S_R_RD;
          end else begin
            row <= row + 1'b1;
            state <= S_R_RD;
          end
        end
        S_R_OFS: begin
          pass <= pass + 1'b1;
          if (32'(pass) < SEED_BYTES) begin
            state <= S_K_RD;
          end else if (32'(pass) == SEED_BYTES) begin
            state <= S_R_PRE;
          end else begin
            hbyte <= offset;
            acc <= offset;
            step <= '0;
            ret <= R_FIN;
            state <= S_H_RD;
          end
        end
        S_K_RD: state <= S_K_WAIT;
        S_K_WAIT: state <= S_K_H1;
        S_K_H1: begin
          cur <= (8'(pos_c) << 4) + 8'(pos_r) + seed[8*kidx[2:0] +: 8] + rdata;
          hbyte <= ((8'(pos_c) << 4) + 8'(pos_r) + seed[8*kidx[2:0] +: 8] + rdata)
                   + offset;
          acc <= offset;
          step <= '0;
          ret <= R_K1;
          state <= S_H_RD;
        end
        S_K_H2: state <= S_H_RD;
        S_K_WR: begin
          kidx <= kidx + 1'b1;
          pos_c <= pos_c + 1'b1;
          if (pos_c == INDEX_BITS'(COLS - 1)) pos_r <= pos_r + 1'b1;
          state <= S_R_PRE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("reseed result nonzero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ===== bench/hash_checker.sv =====
`timescale 1ns / 1ps
module hash_checker #(
  parameter int INDEX_BITS = 4,
  parameter int SEED_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  input  wire logic        m_axis_tuser,
  output int               mismatches,
  output int               pending
);
  import stbh_pkg::*;

  localparam int COLS = 1 << INDEX_BITS;
  localparam int DEPTH = ROWS * COLS;

  typedef struct packed {
    logic [7:0] hash_byte;
    logic       reseeded;
  } hash_result_t;

  logic [7:0] tbl [DEPTH];
  logic [7:0] offset;
  hash_result_t expected_results[$];

  function automatic int entry_at(int r, int c);
    return (r % ROWS) * COLS + (c % COLS);
  endfunction

  function automatic logic [7:0] table_hash(logic [7:0] b);
    logic [15:0] w;
    logic [7:0] acc;
    w = {b, b};
    acc = offset;
    for (int s = 0; s < ROWS; s++) begin
      acc = acc + tbl[entry_at(s, int'(w) & (COLS - 1))];
      w = w >> 1;
    end
    return acc;
  endfunction

  task automatic remix_table();
    logic [7:0] chain;
    chain = table_hash(offset);
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        chain = table_hash(chain + 8'(r) + 8'(c) + tbl[entry_at(r, c)]);
        tbl[entry_at(r, c)] = chain;
      end
    end
    offset = table_hash(offset);
  endtask

  task automatic rebuild_table(logic [63:0] seed);
    logic [7:0] n, sb, cur, a, b;
    int pc, pr;
    n = 0;
    pc = 0;
    pr = 0;
    for (int i = 0; i < DEPTH; i++) tbl[i] = 0;
    for (int c = 0; c < COLS; c++) begin
      for (int r = 0; r < ROWS; r++) begin
        n = n + 1;
        a = n + 8'(c);
        b = n + 8'(r);
        tbl[entry_at(r, c)] = tbl[entry_at(r, c)] + 8'(a * b);
      end
    end
    n = n + 1;
    offset = n;
    remix_table();
    for (int k = 0; k < SEED_BYTES && k < 8; k++) begin
      sb = seed[8*k +: 8];
      cur = 8'(pc << 4) + 8'(pr) + sb + tbl[entry_at(pr, pc)];
      offset = table_hash(cur + offset);
      tbl[entry_at(pr, pc)] = table_hash(cur + offset);
      pc = (pc + 1) % COLS;
      if (pc == 0) pr = (pr + 1) % ROWS;
      remix_table();
    end
    remix_table();
    offset = table_hash(offset);
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    hash_result_t got, exp_r;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) tbl[i] = 0;
      offset = 0;
      mismatches <= 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word hash=%0h reseeded=%0b", $time,
                   got.hash_byte, got.reseeded);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: expected hash=%0h reseeded=%0b, actual hash=%0h reseeded=%0b",
                     $time, exp_r.hash_byte, exp_r.reseeded, got.hash_byte, got.reseeded);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_RESEED) begin
          rebuild_table(s_axis_tdata[71:8]);
          expected_results.push_back('{8'h00, 1'b1});
        end else begin
          expected_results.push_back('{table_hash(s_axis_tdata[7:0]), 1'b0});
        end
      end
    end
  end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import stbh_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;  // data_byte, seed_value
  logic        s_axis_tuser;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // hash_byte
  logic        m_axis_tuser;  // reseeded
  int          mismatches;
  int          pending;
  int          idle_cycles;
  bit          send_bursty;
  bit          recv_bursty;
  int          stall_left;

  seeded_tabulated_byte_hash_unit uut (.*);

  hash_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls: a random number of cycles per word, or none in a burst stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (recv_bursty) begin
        stall_left <= 0;
        m_axis_tready <= 1;
      end else begin
        stall_left <= $urandom_range(0, 15);
        m_axis_tready <= 0;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [7:0] data, logic [63:0] seed);
    int gap;
    gap = send_bursty ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {seed, data};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [63:0] rand_seed();
    return {$urandom, $urandom};
  endfunction

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    send_bursty = 0;
    recv_bursty = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero table, then extremes of both fields
    send_word(OP_HASH, 8'h00, 64'h0);
    send_word(OP_HASH, 8'hFF, rand_seed());
    send_word(OP_RESEED, 8'hFF, 64'h0);
    send_word(OP_HASH, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_HASH, 8'hFF, 64'h0);
    send_word(OP_HASH, 8'h55, rand_seed());
    send_word(OP_HASH, 8'hAA, rand_seed());
    send_word(OP_RESEED, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_HASH, 8'h01, rand_seed());
    send_word(OP_HASH, 8'h80, rand_seed());
    send_word(OP_RESEED, 8'($urandom), 64'h8000_0000_0000_0001);
    send_word(OP_RESEED, 8'($urandom), 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 8; i++) send_word(OP_HASH, 8'(1 << i), rand_seed());

    // drain fully before random traffic
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 1300; i++) begin
      if (i % 100 == 0) begin
        send_bursty = ($urandom_range(0, 3) == 0);
        recv_bursty = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 2)
        send_word(OP_RESEED, 8'($urandom), rand_seed());
      else
        send_word(OP_HASH, 8'($urandom), rand_seed());
    end
    s_axis_tvalid <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/stbh_pkg.sv
rtl/seeded_tabulated_byte_hash_unit.sv
bench/hash_checker.sv
bench/testbench.sv
